// ===== rtl/pwdm_pkg.sv =====
// Shared types, constants and microcode ROM for the pulse width / duty meter.
`timescale 1ns / 1ps

package pwdm_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;

    localparam int MS_W    = 16;   // millisecond values
    localparam int SUM_W   = 17;   // high_ms + low_ms
    localparam int PROD_W  = 23;   // high_ms * 100
    localparam int DUTY_W  = 7;
    localparam int PULSE_W = 8;
    localparam int DEN_W   = 17;   // divider denominator

    localparam logic [15:0]       TICKS_PER_MS_RST = 16'd125;
    localparam logic [15:0]       DEBOUNCE_MS_RST  = 16'd80;
    localparam logic [DUTY_W-1:0] PERCENT          = 7'd100;

    // input opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // report kinds
    localparam logic RPT_ASTABLE = 1'b0;
    localparam logic RPT_MONO    = 1'b1;

    // register indexes
    localparam logic REG_TICKS_PER_MS = 1'b0;
    localparam logic REG_DEBOUNCE_MS  = 1'b1;

    localparam int PC_W = 4;

    // program entry points
    localparam logic [PC_W-1:0] PC_ASTABLE = 4'd0;
    localparam logic [PC_W-1:0] PC_MONO    = 4'd8;

    typedef enum logic [1:0] {
        NUM_HIGH,
        NUM_LOW,
        NUM_PROD,
        NUM_TICK
    } num_sel_t;

    typedef enum logic {
        DEN_TPMS,
        DEN_SUM
    } den_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_HI,
        WB_LO,
        WB_DUTY,
        WB_DUR
    } wb_sel_t;

    typedef enum logic {
        JC_NEXT,
        JC_SUM_ZERO
    } jump_t;

    typedef struct packed {
        logic            start;   // launch a divide
        num_sel_t        num_sel;
        den_sel_t        den_sel;
        logic            wait_div; // hold until the divide finishes
        wb_sel_t         wb;
        logic            prep;    // form sum and product, clear duty
        jump_t           jc;
        logic [PC_W-1:0] target;
        logic            emit;    // load the output register
        logic            kind;
        logic            fin;     // back to idle
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{start: 1'b0, num_sel: NUM_HIGH, den_sel: DEN_TPMS, wait_div: 1'b0,
              wb: WB_NONE, prep: 1'b0, jc: JC_NEXT, target: '0, emit: 1'b0,
              kind: RPT_ASTABLE, fin: 1'b0};
        case (pc)
            4'd0:
            begin
                w.start   = 1'b1;
                w.num_sel = NUM_HIGH;
            end
            4'd1:
            begin
                w.wait_div = 1'b1;
                w.wb       = WB_HI;
            end
            4'd2:
            begin
                w.start   = 1'b1;
                w.num_sel = NUM_LOW;
            end
            4'd3:
            begin
                w.wait_div = 1'b1;
                w.wb       = WB_LO;
            end
            4'd4:
            begin
                w.prep = 1'b1;
            end
            4'd5:
            begin
                w.start   = 1'b1;
                w.num_sel = NUM_PROD;
                w.den_sel = DEN_SUM;
                w.jc      = JC_SUM_ZERO;
                w.target  = 4'd7;
            end
            4'd6:
            begin
                w.wait_div = 1'b1;
                w.wb       = WB_DUTY;
            end
            4'd7:
            begin
                w.emit = 1'b1;
                w.kind = RPT_ASTABLE;
                w.fin  = 1'b1;
            end
            4'd8:
            begin
                w.start   = 1'b1;
                w.num_sel = NUM_TICK;
            end
            4'd9:
            begin
                w.wait_div = 1'b1;
                w.wb       = WB_DUR;
            end
            4'd10:
            begin
                w.emit = 1'b1;
                w.kind = RPT_MONO;
                w.fin  = 1'b1;
            end
            default:
            begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pwdm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pwdm_div
    import pwdm_pkg::*;
#(
    parameter int NUM_W = PROD_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;   // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = num;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== rtl/pulse_width_duty_meter_top.sv =====
// Top level of the pulse width and duty cycle meter.
`timescale 1ns / 1ps

// Pulse width / duty meter. Each transfer on the input stream is either a timer
// tick (tuser = 0) or a clock-pin edge (tuser = 1). A tick bumps a wrapping
// COUNTER_WIDTH-bit counter. In astable mode an edge captures the count as low
// time (rising) or high time (falling), clears the counter and produces one
// report with both counts and the duty percentage, computed on millisecond
// values. In monostable mode a rising edge clears the counter and a falling edge
// reports pulse number, duration in ms and a bounce flag. Edge work is run by a
// small microcode program over one shared restoring divider that yields one
// quotient bit per cycle over NUM_W = max(COUNTER_WIDTH, 23) bits; that divider
// sets the rate. An astable edge divides for high time, low time and duty (the
// duty divide is skipped when the period is zero), a monostable falling edge for
// the duration only. A report that cannot leave because the previous one is
// still waiting for m_tready holds its program until then. The input is not
// ready while a program runs. A finished report sits in an output register, so
// new ticks are taken while it waits for m_tready.
// Registers (APB, byte addresses): 0x0 ticks_per_ms (reset 125, 0 acts as 1),
// 0x4 debounce_ms (reset 80).

module pulse_width_duty_meter_top
    import pwdm_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pin_level, [1] mode_select, [7:2] zero
    input  logic        s_tuser,   // [0] opcode

    // report stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] pulse_number, [23:8] high_count,
                                   // [39:24] low_count, [46:40] duty_percent,
                                   // [62:47] duration_ms, [63] bounced
    output logic        m_tuser,   // [0] report_kind

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NUM_W = (COUNTER_WIDTH > PROD_W) ? COUNTER_WIDTH : PROD_W;
    localparam int CW    = COUNTER_WIDTH;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] tpms_reg;
    logic [15:0] debounce_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpms_reg     <= TICKS_PER_MS_RST;
            debounce_reg <= DEBOUNCE_MS_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_TICKS_PER_MS)
            begin
                tpms_reg <= pwdata[15:0];
            end
            else
            begin
                debounce_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TICKS_PER_MS)
        begin
            prdata = {16'd0, tpms_reg};
        end
        else
        begin
            prdata = {16'd0, debounce_reg};
        end
    end

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic in_xfer;
    logic pin_level;
    logic astable;

    assign pin_level = s_tdata[0];
    assign astable   = s_tdata[1];
    assign in_xfer   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // sequencer and datapath
    // ------------------------------------------------------------------
    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [CW-1:0]     tick_reg, tick_next;
    logic [CW-1:0]     high_reg, high_next;
    logic [CW-1:0]     low_reg, low_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [MS_W-1:0]   hi_ms_reg, hi_ms_next;
    logic [MS_W-1:0]   lo_ms_reg, lo_ms_next;
    logic [MS_W-1:0]   dur_reg, dur_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;
    logic              out_kind_reg, out_kind_next;

    ucode_t            uc;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [MS_W-1:0]   quot_ms;
    logic              sum_zero;
    logic              out_free;
    logic [15:0]       tpms_eff;

    assign uc       = ucode_rom(pc_reg);
    assign sum_zero = (sum_reg == '0);
    assign out_free = !out_valid_reg || m_tready;
    assign tpms_eff = (tpms_reg == 16'd0) ? 16'd1 : tpms_reg;

    // ms values saturate when the counter is wider than 16 bits
    assign quot_ms = (|div_quot[NUM_W-1:MS_W]) ? {MS_W{1'b1}} : div_quot[MS_W-1:0];

    assign div_start = busy_reg && uc.start && !(uc.jc == JC_SUM_ZERO && sum_zero);

    always_comb
    begin
        case (uc.num_sel)
            NUM_HIGH: div_num = NUM_W'(high_reg);
            NUM_LOW:  div_num = NUM_W'(low_reg);
            NUM_PROD: div_num = NUM_W'(prod_reg);
            NUM_TICK: div_num = NUM_W'(tick_reg);
            default:  div_num = '0;
        endcase
    end

    assign div_den = (uc.den_sel == DEN_SUM) ? sum_reg : {1'b0, tpms_eff};

    pwdm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        tick_next      = tick_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        pulse_next     = pulse_reg;
        hi_ms_next     = hi_ms_reg;
        lo_ms_next     = lo_ms_reg;
        dur_next       = dur_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;

        if (in_xfer)
        begin
            if (s_tuser == OP_TICK)
            begin
                tick_next = tick_reg + 1'b1;
            end
            else if (astable)
            begin
                if (pin_level)
                begin
                    low_next = tick_reg;
                end
                else
                begin
                    high_next = tick_reg;
                end
                tick_next = '0;
                busy_next = 1'b1;
                pc_next   = PC_ASTABLE;
            end
            else if (pin_level)
            begin
                tick_next = '0;
            end
            else
            begin
                busy_next = 1'b1;
                pc_next   = PC_MONO;
            end
        end
        else if (busy_reg)
        begin
            if (uc.wait_div)
            begin
                if (div_done)
                begin
                    case (uc.wb)
                        WB_HI:   hi_ms_next = quot_ms;
                        WB_LO:   lo_ms_next = quot_ms;
                        WB_DUTY: duty_next  = div_quot[DUTY_W-1:0];
                        WB_DUR:  dur_next   = quot_ms;
                        default: ;
                    endcase
                    pc_next = pc_reg + 1'b1;
                end
            end
            else if (uc.emit)
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = uc.kind;
                    if (uc.kind == RPT_ASTABLE)
                    begin
                        out_data_next = {1'b0, {MS_W{1'b0}}, duty_reg,
                                         MS_W'(low_reg), MS_W'(high_reg),
                                         {PULSE_W{1'b0}}};
                    end
                    else
                    begin
                        out_data_next = {(dur_reg < debounce_reg), dur_reg,
                                         {DUTY_W{1'b0}}, {MS_W{1'b0}}, {MS_W{1'b0}},
                                         pulse_reg};
                        pulse_next    = pulse_reg + 1'b1;
                    end
                    busy_next = 1'b0;
                end
            end
            else if (uc.fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (uc.prep)
                begin
                    sum_next  = SUM_W'(hi_ms_reg) + SUM_W'(lo_ms_reg);
                    prod_next = PROD_W'(hi_ms_reg) * PROD_W'(PERCENT);
                    duty_next = '0;
                end
                if (uc.jc == JC_SUM_ZERO && sum_zero)
                begin
                    pc_next = uc.target;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            tick_reg      <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            pulse_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            tick_reg      <= tick_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            pulse_reg     <= pulse_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // scratch and payload registers
    always_ff @(posedge clk)
    begin
        hi_ms_reg    <= hi_ms_next;
        lo_ms_reg    <= lo_ms_next;
        dur_reg      <= dur_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        duty_reg     <= duty_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule
